// ===== design/bbs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants of the bidirectional bubble sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

  // Store depth and derived widths
  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_PRIME,
    ST_STEP,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_EMIT_HOLD
  } st_t;

  // Result of one compare-exchange step
  typedef struct packed {
    logic  swap;
    data_t wr_val;
    data_t carry;
  } cx_res_t;

endpackage

`default_nettype wire

// ===== design/bbs_in_if.sv =====
// ----------------------------------------------------------------------------
// bbs_in_if
// Input channel: one unsorted value per transfer, last_item closes the set.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbs_in_if;
  import bbs_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

`default_nettype wire

// ===== design/bbs_out_if.sv =====
// ----------------------------------------------------------------------------
// bbs_out_if
// Result channel: one sorted value per transfer, last_item_res marks the end.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbs_out_if;
  import bbs_pkg::*;

  logic  valid;
  logic  ready;
  data_t value_res;
  logic  last_item_res;

  modport source (output valid, output value_res, output last_item_res, input ready);
  modport sink   (input valid, input value_res, input last_item_res, output ready);
endinterface

`default_nettype wire

// ===== design/bidirectional_bubble_sorter.sv =====
// Load: one cycle per input transfer; store holds up to MAX_ITEMS values.
// Sort: a backward pass runs bound check, prime, steps and fin; a forward
//   pass skips the bound check; all passes use the single compare-exchange unit.
// Emit: each result passes read, output and hold states; no input taken meanwhile.
// Reset: sequencer returns to load, count clears; store contents undefined.
// ----------------------------------------------------------------------------
// bidirectional_bubble_sorter
// Cocktail shaker sorter: loads signed values, sorts ascending in place,
// then streams the sorted set out with the final element marked.
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_bubble_sorter
  import bbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  bbs_in_if.sink    in_ch,
  bbs_out_if.source out_ch
);

  st_t     state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  idx_t    lo_r, lo_nxt;
  idx_t    hi_r, hi_nxt;
  idx_t    idx_r, idx_nxt;
  idx_t    mark_r, mark_nxt;
  data_t   carry_r, carry_nxt;
  logic    fwd_r, fwd_nxt;
  logic    out_valid_r, out_valid_nxt;
  data_t   out_value_r, out_value_nxt;
  logic    out_last_r, out_last_nxt;

  data_t   mem_r [MAX_ITEMS];
  logic    we;
  idx_t    wr_addr;
  data_t   wr_data;
  idx_t    rd_addr;
  data_t   rd_data_r;
  logic    in_ready;
  cx_res_t cx;

  // Compare-exchange on carry and the neighbor just read
  bbs_cx_unit u_cx (
    .carry (carry_r),
    .nbr   (rd_data_r),
    .fwd   (fwd_r),
    .res   (cx)
  );

  // Element store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    idx_r       <= idx_nxt;
    mark_r      <= mark_nxt;
    carry_r     <= carry_nxt;
    fwd_r       <= fwd_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer: load, shaker passes, emit
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    mark_nxt      = mark_r;
    carry_nxt     = carry_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    we            = 1'b0;
    wr_addr       = idx_r;
    wr_data       = cx.wr_val;
    rd_addr       = idx_r;
    in_ready      = 1'b0;

    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          // Store while there is room, drop beyond capacity
          if (cnt_r < CNT_W'(MAX_ITEMS)) begin
            we      = 1'b1;
            wr_addr = cnt_r[IDX_W-1:0];
            wr_data = in_ch.value;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_ch.last_item) begin
            lo_nxt    = '0;
            hi_nxt    = IDX_W'(cnt_nxt - CNT_W'(1));
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (lo_r < hi_r) begin
          // Start a backward pass from the upper bound
          fwd_nxt   = 1'b0;
          idx_nxt   = hi_r;
          mark_nxt  = hi_r;
          rd_addr   = hi_r;
          state_nxt = ST_PRIME;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end
      end

      ST_PRIME: begin
        // Pick up the first element as the carry, fetch its neighbor
        carry_nxt = rd_data_r;
        rd_addr   = fwd_r ? idx_r + IDX_W'(1) : idx_r - IDX_W'(1);
        state_nxt = ST_STEP;
      end

      ST_STEP: begin
        we        = 1'b1;
        wr_addr   = idx_r;
        wr_data   = cx.wr_val;
        carry_nxt = cx.carry;
        if (cx.swap) begin
          mark_nxt = idx_r;
        end
        if (fwd_r) begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_nxt + IDX_W'(1);
          if (!(idx_nxt < hi_r)) begin
            state_nxt = ST_FIN;
          end
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
          rd_addr = idx_nxt - IDX_W'(1);
          if (!(idx_nxt > lo_r)) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        // Drop the carry into the end slot, shrink the bound
        we      = 1'b1;
        wr_addr = idx_r;
        wr_data = carry_r;
        if (!fwd_r) begin
          lo_nxt = mark_r;
          if (mark_r < hi_r) begin
            fwd_nxt   = 1'b1;
            idx_nxt   = mark_r;
            rd_addr   = mark_r;
            state_nxt = ST_PRIME;
          end else begin
            state_nxt = ST_CHECK;
          end
        end else begin
          hi_nxt    = mark_r;
          state_nxt = ST_CHECK;
        end
      end

      ST_EMIT_RD: begin
        rd_addr   = idx_r;
        state_nxt = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data_r;
        out_last_nxt  = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
        state_nxt     = ST_EMIT_HOLD;
      end

      ST_EMIT_HOLD: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.value_res     = out_value_r;
  assign out_ch.last_item_res = out_last_r;

endmodule

`default_nettype wire

// ===== design/bbs_cx_unit.sv =====
// ----------------------------------------------------------------------------
// bbs_cx_unit
// Shared compare-exchange unit. The carried value bubbles through the store;
// each step writes back one element and keeps one in the carry register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_cx_unit
  import bbs_pkg::*;
(
  input  wire data_t   carry,
  input  wire data_t   nbr,
  input  wire logic    fwd,
  output cx_res_t      res
);

  logic swap;

  // Backward pass keeps the smaller value moving down, forward the larger up
  assign swap = fwd ? (nbr < carry) : (carry < nbr);

  always_comb begin
    res.swap   = swap;
    res.wr_val = swap ? nbr : carry;
    res.carry  = swap ? carry : nbr;
  end

endmodule

`default_nettype wire

// ===== design/bbs_checker.sv =====
// ----------------------------------------------------------------------------
// bbs_checker
// Port-level checks of the sorter: hold on stall, no overlap of load and
// emit, and hand-off between the phases after a final transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_checker
  import bbs_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  in_last_item,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire data_t out_value_res,
  input wire logic  out_last_item_res
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res)
                               && $stable(out_last_item_res))
    else $error("result changed while stalled");

  // Never load and emit at once
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // A final input transfer closes loading
  a_close_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_item |=> !in_ready)
    else $error("input still ready after final transfer");

  // The final result transfer ends emitting and reopens loading
  a_end_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_item_res |=> !out_valid && in_ready)
    else $error("sorter did not return to load after final result");

endmodule

bind bidirectional_bubble_sorter bbs_checker u_bbs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_last_item      (in_ch.last_item),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_value_res     (out_ch.value_res),
  .out_last_item_res (out_ch.last_item_res)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bidirectional bubble sorter. Streams data sets
// of mixed sizes (single values, duplicates, sign extremes, full and overfull
// sets) through the input channel under random gaps and back-pressure. Every
// sorted output transfer is checked against an in-bench shaker-sort predictor.
// ----------------------------------------------------------------------------

module tb;
  import bbs_pkg::*;

  localparam int    RANDOM_ITEMS  = 170;
  localparam int    IDLE_PERCENT  = 8;
  localparam int    HOLD_CYCLES   = 400;
  localparam int    SETTLE_CYCLES = 200;
  localparam int    MAX_REPORTS   = 10;
  localparam data_t DATA_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t DATA_MAX      = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    data_t value;
    logic  last_item;
    logic  drain;    // offer only once every sorted value has come back
    logic  steady;   // no random gaps on either side while this is offered
    logic  hold_rx;  // kick off the long receiver hold-off
  } feed_item_t;

  typedef struct packed {
    data_t value;
    logic  last_item;
  } sorted_item_t;

  logic clk;
  logic rst_n;

  bbs_in_if  in_bus ();
  bbs_out_if out_bus ();

  bidirectional_bubble_sorter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  feed_item_t   feed_q[$];
  sorted_item_t sorted_q[$];

  // Predictor state: values of the set being loaded
  data_t held [MAX_ITEMS];
  int    held_cnt;
  logic  set_overfull;

  logic in_took;
  logic steady;
  logic hold_kick;
  logic hold_used;
  int   hold_left;

  int err_cnt;
  int sets_sorted;
  int sets_overfull;
  int items_dropped;
  int items_fed;
  int results_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #5_000_000;
    $display("Timeout with %0d sorted values still outstanding", sorted_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  // Store one value; on a closing item, shaker-sort the set and queue its output
  task automatic absorb_value(input data_t v, input logic last);
    int           lo;
    int           hi;
    int           mark;
    int           i;
    data_t        t;
    sorted_item_t s;
    if (held_cnt < MAX_ITEMS) begin
      held[held_cnt] = v;
      held_cnt++;
    end else begin
      set_overfull = 1'b1;
      items_dropped++;
    end
    if (last) begin
      lo = 0;
      hi = held_cnt - 1;
      while (lo < hi) begin
        // backward pass: sink the smallest value toward lo
        mark = hi;
        for (i = hi; i > lo; i--) begin
          if (held[i] < held[i-1]) begin
            t         = held[i];
            held[i]   = held[i-1];
            held[i-1] = t;
            mark      = i;
          end
        end
        lo = mark;
        // forward pass: raise the largest value toward hi
        mark = lo;
        for (i = lo; i < hi; i++) begin
          if (held[i+1] < held[i]) begin
            t         = held[i];
            held[i]   = held[i+1];
            held[i+1] = t;
            mark      = i;
          end
        end
        hi = mark;
      end
      for (i = 0; i < held_cnt; i++) begin
        s.value     = held[i];
        s.last_item = (i == held_cnt - 1);
        sorted_q.push_back(s);
      end
      sets_sorted++;
      if (set_overfull) sets_overfull++;
      set_overfull = 1'b0;
      held_cnt     = 0;
    end
  endtask

  // Sample both channels; predict on input transfers, check output transfers
  always @(posedge clk) begin : sample_side
    sorted_item_t want;
    in_took <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      items_fed++;
      absorb_value(in_bus.value, in_bus.last_item);
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        flag_error($sformatf("unexpected output %0d last=%0b",
                             out_bus.value_res, out_bus.last_item_res));
      end else begin
        want = sorted_q.pop_front();
        if (out_bus.value_res !== want.value) begin
          flag_error($sformatf("value_res: expected %0d, got %0d",
                               want.value, out_bus.value_res));
        end
        if (out_bus.last_item_res !== want.last_item) begin
          flag_error($sformatf("last_item_res: expected %0b, got %0b (value %0d)",
                               want.last_item, out_bus.last_item_res, want.value));
        end
      end
    end
  end

  // Driver: hold the offered item until it transfers, then advance
  always @(negedge clk) begin : drive_side
    feed_item_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_took) begin
      // keep offering the same item
    end else if (feed_q.size() == 0 ||
                 (!steady && $urandom_range(99) < IDLE_PERCENT) ||
                 (feed_q[0].drain && sorted_q.size() != 0)) begin
      in_bus.valid <= 1'b0;
    end else begin
      nxt = feed_q.pop_front();
      in_bus.valid     <= 1'b1;
      in_bus.value     <= nxt.value;
      in_bus.last_item <= nxt.last_item;
      steady           <= nxt.steady;
      if (nxt.hold_rx) hold_kick <= 1'b1;
    end
  end

  // Long receiver hold-off, counted down once after the kick
  always @(negedge clk) begin
    if (hold_kick && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls unless in a steady stretch or held off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= (hold_left == 0) &&
                       (steady || $urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic push_item(input data_t v, input logic last, input logic drain,
                           input logic steady_f, input logic hold);
    feed_item_t f;
    f.value     = v;
    f.last_item = last;
    f.drain     = drain;
    f.steady    = steady_f;
    f.hold_rx   = hold;
    feed_q.push_back(f);
  endtask

  // Mix of sign extremes, a narrow band for duplicates, and full-range values
  function automatic data_t pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(3))
        0:       return DATA_MIN;
        1:       return DATA_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end else if (sel < 35) begin
      return data_t'($urandom_range(6)) - 3;
    end
    return data_t'($urandom);
  endfunction

  task automatic add_set(input int n, input logic drain, input logic steady_f,
                         input logic hold);
    int k;
    for (k = 0; k < n; k++) begin
      push_item(pick_value(), k == n - 1, drain && k == 0, steady_f, hold && k == 0);
    end
  endtask

  initial begin
    int goal;
    int set_no;
    int sel;
    int n;
    int k;

    in_bus.valid     = 1'b0;
    in_bus.value     = '0;
    in_bus.last_item = 1'b0;
    out_bus.ready    = 1'b0;
    rst_n            = 1'b0;
    in_took          = 1'b0;
    steady           = 1'b0;
    hold_kick        = 1'b0;
    hold_used        = 1'b0;
    hold_left        = 0;
    held_cnt         = 0;
    set_overfull     = 1'b0;
    err_cnt          = 0;
    sets_sorted      = 0;
    sets_overfull    = 0;
    items_dropped    = 0;
    items_fed        = 0;
    results_seen     = 0;

    // Single-value sets at both sign extremes
    push_item(DATA_MIN, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(DATA_MAX, 1'b1, 1'b0, 1'b0, 1'b0);
    // Two values in reverse order, then alternating bit patterns
    push_item(DATA_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(DATA_MIN, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(data_t'(32'hAAAA_AAAA), 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(data_t'(32'h5555_5555), 1'b1, 1'b0, 1'b0, 1'b0);
    // Duplicates across the sign boundary
    push_item('0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item('1, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(DATA_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item('1, 1'b1, 1'b0, 1'b0, 1'b0);
    // Strictly descending set
    for (k = 5; k >= 1; k--) begin
      push_item(data_t'(k * 1000 - 2500), k == 1, 1'b0, 1'b0, 1'b0);
    end

    // Random sets: mostly small, some full, some overfull
    goal   = feed_q.size() + RANDOM_ITEMS;
    set_no = 0;
    while (feed_q.size() < goal) begin
      sel = $urandom_range(99);
      if (set_no == 0)      n = MAX_ITEMS;
      else if (set_no == 2) n = MAX_ITEMS + 2;
      else if (sel < 70)    n = $urandom_range(6, 1);
      else if (sel < 85)    n = $urandom_range(MAX_ITEMS - 1, 7);
      else if (sel < 93)    n = MAX_ITEMS;
      else                  n = $urandom_range(MAX_ITEMS + 4, MAX_ITEMS + 1);
      add_set(n,
              set_no == 0 || set_no == 20 || (set_no > 2 && $urandom_range(19) == 0),
              set_no >= 8 && set_no < 16,
              set_no == 1);
      set_no++;
    end

    // Reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain all stimulus and outstanding results, then let stray outputs show
    while (feed_q.size() != 0 || in_bus.valid || sorted_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d data sets (%0d overfull, %0d values dropped) from %0d input items",
             sets_sorted, sets_overfull, items_dropped, items_fed);
    $display("Checked %0d sorted output values, %0d mismatches", results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
